[rtl/ipv4_text_range_classifier_macros.svh]
// Assertion macros for the IPv4 text range classifier.
`ifndef IPV4_TEXT_RANGE_CLASSIFIER_MACROS_SVH
`define IPV4_TEXT_RANGE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ITRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ITRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/itrc_pkg.sv]
// Package with shared types and constants of the IPv4 text range classifier.
`timescale 1ns / 1ps
`default_nettype none
package itrc_pkg;

    // Request kinds
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_CHAR = 1'b1;

    // Characters of the address text
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;
    localparam logic [7:0] CHAR_DOT  = 8'd46;

    // Octet limits and dot count
    localparam logic [8:0] OCTET_MAX = 9'd255;
    localparam logic [8:0] OCTET_SAT = 9'd256;
    localparam logic [1:0] DOT_LAST  = 2'd3;

    localparam int ENTRY_W = 64;

    typedef struct packed {
        logic        func;
        logic [7:0]  entry_index;
        logic [31:0] range_low;
        logic [31:0] range_high;
        logic [7:0]  char_code;
        logic        last_char;
    } t_in_req;

    typedef struct packed {
        logic [31:0] address;
        logic [8:0]  bucket;
        logic        malformed;
    } t_result;

    typedef struct packed {
        logic [31:0] address;
        logic        malformed;
    } t_parse_res;

    typedef struct packed {
        logic busy;
        logic done;
    } t_srch_status;

endpackage
`default_nettype wire

[rtl/itrc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module itrc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read one entry each cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/itrc_parse.sv]
// Dotted-decimal character accumulator that forms the 32-bit address.
`timescale 1ns / 1ps
`default_nettype none
module itrc_parse
    import itrc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_char,
    input  wire logic       i_last,
    output t_parse_res      o_result
);

    logic [8:0]  r_octet, n_octet;
    logic [23:0] r_addr, n_addr;
    logic [1:0]  r_dots, n_dots;
    logic        r_err, n_err;
    logic [7:0]  w_digit;
    logic [12:0] w_value;
    logic [7:0]  w_contrib;
    logic [7:0]  w_n_contrib;

    assign w_digit   = i_char - CHAR_ZERO;
    assign w_value   = {1'b0, r_octet, 3'b000} + {3'b000, r_octet, 1'b0}
                     + {9'd0, w_digit[3:0]};
    assign w_contrib = (r_octet > OCTET_MAX) ? 8'hFF : r_octet[7:0];

    // Apply one character to the parse state
    always_comb begin
        n_octet = r_octet;
        n_addr  = r_addr;
        n_dots  = r_dots;
        n_err   = r_err;
        if (i_char >= CHAR_ZERO && i_char <= CHAR_NINE) begin
            if (w_value > {4'd0, OCTET_MAX}) begin
                n_err   = 1'b1;
                n_octet = OCTET_SAT;
            end else begin
                n_octet = w_value[8:0];
            end
        end else if (i_char == CHAR_DOT) begin
            if (r_dots == DOT_LAST) begin
                n_err = 1'b1;
            end else begin
                n_addr  = {r_addr[15:0], w_contrib};
                n_octet = '0;
                n_dots  = r_dots + 2'd1;
            end
        end else begin
            n_err = 1'b1;
        end
    end

    assign w_n_contrib        = (n_octet > OCTET_MAX) ? 8'hFF : n_octet[7:0];
    assign o_result.address   = {n_addr, w_n_contrib};
    assign o_result.malformed = n_err;

    // Advance on each character; clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_octet <= '0;
            r_addr  <= '0;
            r_dots  <= '0;
            r_err   <= 1'b0;
        end else if (i_take) begin
            r_octet <= n_octet;
            r_addr  <= n_addr;
            r_dots  <= n_dots;
            r_err   <= n_err;
        end
    end

endmodule
`default_nettype wire

[rtl/itrc_search.sv]
// Binary search sequencer over the range table memory.
`timescale 1ns / 1ps
`default_nettype none
module itrc_search
    import itrc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire t_parse_res                       i_parse,
    input  wire logic [8:0]                       i_entries,
    input  wire logic                             i_take,
    output t_srch_status                          o_status,
    output t_result                               o_result,
    output logic [$clog2(TABLE_ENTRIES)-1:0]      o_raddr,
    input  wire logic [ENTRY_W-1:0]               i_rdata
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int SW = (CW > 9) ? CW : 9;
    localparam logic [SW-1:0] TE_S = SW'(TABLE_ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADDR = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [SW-1:0] r_lo, n_lo;
    logic [SW-1:0] r_hi, n_hi;
    logic [SW-1:0] r_mid, n_mid;
    logic [SW-1:0] r_n, n_n;
    logic [SW-1:0] r_bucket, n_bucket;
    logic [31:0]   r_addr, n_addr;
    logic          r_err, n_err;
    logic [SW:0]   w_sum;
    logic [SW-1:0] w_mid;
    logic [SW-1:0] w_cfg;
    logic [31:0]   w_low, w_high;

    assign w_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid  = w_sum[SW:1];
    assign w_cfg  = SW'(i_entries);
    assign w_low  = i_rdata[ENTRY_W-1:32];
    assign w_high = i_rdata[31:0];

    assign o_raddr = w_mid[AW-1:0];

    // Step the search: issue a read, then compare and narrow
    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_n      = r_n;
        n_bucket = r_bucket;
        n_addr   = r_addr;
        n_err    = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_addr  = i_parse.address;
                    n_err   = i_parse.malformed;
                    n_n     = (w_cfg > TE_S) ? TE_S : w_cfg;
                    n_lo    = '0;
                    n_hi    = n_n;
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                if (r_lo < r_hi) begin
                    n_mid   = w_mid;
                    n_state = S_CMP;
                end else begin
                    n_bucket = r_n;
                    n_state  = S_DONE;
                end
            end
            S_CMP: begin
                priority if (r_addr < w_low) begin
                    n_hi    = r_mid;
                    n_state = S_ADDR;
                end else if (r_addr > w_high) begin
                    n_lo    = r_mid + SW'(1);
                    n_state = S_ADDR;
                end else begin
                    n_bucket = r_mid;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state under reset; payload registers follow freely
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_n      <= n_n;
        r_bucket <= n_bucket;
        r_addr   <= n_addr;
        r_err    <= n_err;
    end

    assign o_status.busy    = (r_state != S_IDLE);
    assign o_status.done    = (r_state == S_DONE);
    assign o_result.address = r_addr;
    assign o_result.bucket  = r_bucket[8:0];
    assign o_result.malformed = r_err;

endmodule
`default_nettype wire

[rtl/ipv4_text_range_classifier.sv]
// Character and load requests are taken whenever the input is not stalled; a load is one table write.
// Last character: the parsed address is searched in S binary-search steps (at most 9 for
// 256 entries), a step being one read and compare, and the result is then registered.
// The input is stalled while a search runs and while its result waits for the output.
// Synchronous active-low reset clears the parse state, search control, output valid and
// the entry count; the range table is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_text_range_classifier
    import itrc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_in_req    i_req,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_result         o_res,
    input  wire logic       i_cfg_we,
    input  wire logic [8:0] i_cfg_data
);

    `include "ipv4_text_range_classifier_macros.svh"

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int SW = (CW > 9) ? CW : 9;
    localparam logic [SW-1:0] TE_S = SW'(TABLE_ENTRIES);

    logic [8:0]         r_entries;
    logic               r_out_valid;
    t_result            r_res;
    logic               w_accept;
    logic               w_char;
    logic               w_start;
    logic               w_load;
    logic [SW-1:0]      w_slot;
    logic               w_take;
    t_parse_res         w_parse;
    t_srch_status       w_status;
    t_result            w_srch_res;
    logic [AW-1:0]      w_raddr;
    logic [ENTRY_W-1:0] w_rdata;

    // Accept requests only while no search is in flight
    assign o_stall  = w_status.busy;
    assign w_accept = i_valid && !o_stall;
    assign w_char   = w_accept && (i_req.func == FUNC_CHAR);
    assign w_start  = w_char && i_req.last_char;
    assign w_slot   = SW'(i_req.entry_index);
    assign w_load   = w_accept && (i_req.func == FUNC_LOAD) && (w_slot < TE_S);

    // Entry count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (i_cfg_we) begin
            r_entries <= i_cfg_data;
        end
    end

    itrc_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_char),
        .i_char   (i_req.char_code),
        .i_last   (i_req.last_char),
        .o_result (w_parse)
    );

    itrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_slot[AW-1:0]),
        .i_wdata ({i_req.range_low, i_req.range_high}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    itrc_search #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_parse   (w_parse),
        .i_entries (r_entries),
        .i_take    (w_take),
        .o_status  (w_status),
        .o_result  (w_srch_res),
        .o_raddr   (w_raddr),
        .i_rdata   (w_rdata)
    );

    // Move a finished search into the output register when it is free
    assign w_take = w_status.done && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_res <= w_srch_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    `ITRC_ASSERT_NEXT(a_last_starts_search, w_start, w_status.busy,
        "last character did not start a search")
    `ITRC_ASSERT_NOW(a_out_from_search, $rose(o_valid), $past(w_status.done),
        "result appeared without a finished search")
    `ITRC_ASSERT_NEXT(a_take_frees_search, w_take, !w_status.busy && o_valid,
        "search not released after its result was taken")

endmodule
`default_nettype wire

[tb/testbench.sv]
// Testbench for the IPv4 text range classifier: parse, range search and back-pressure checks.
`timescale 1ns / 1ps
module testbench;
    import itrc_pkg::*;

    localparam int TABLE_DEPTH    = 256;
    localparam int SEARCH_DRAIN   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int HOLD_CYCLES    = 300;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    t_in_req    i_req      = '0;
    logic       i_stall    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [8:0] i_cfg_data = '0;
    logic       o_stall;
    logic       o_valid;
    t_result    o_res;

    // Predictor state: range table, entry count and the address being parsed
    logic [31:0] table_low  [TABLE_DEPTH];
    logic [31:0] table_high [TABLE_DEPTH];
    int          entries_cfg = 0;
    logic [8:0]  octet_acc   = '0;
    logic [23:0] addr_acc    = '0;
    logic [1:0]  dots_seen   = '0;
    logic        text_bad    = 1'b0;
    t_result     expected_results[$];

    logic [7:0]  text_buf[$];
    int          tx_idle_pct     = 0;
    int          rx_idle_pct     = 0;
    int          rx_hold_request = 0;
    int          rx_hold_left    = 0;
    int          mismatch_count  = 0;
    int          stuck_cycles    = 0;

    ipv4_text_range_classifier #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic int active_entries();
        return (entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH : entries_cfg;
    endfunction

    function automatic logic [7:0] octet_byte();
        return (octet_acc > OCTET_MAX) ? OCTET_MAX[7:0] : octet_acc[7:0];
    endfunction

    // Binary search over the active entries; no match gives the entry count
    function automatic logic [8:0] search_bucket(input logic [31:0] addr);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = active_entries();
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (addr < table_low[mid])
                hi = mid;
            else if (addr > table_high[mid])
                lo = mid + 1;
            else
                return 9'(mid);
        end
        return 9'(active_entries());
    endfunction

    // Advance the predictor by one accepted request
    function automatic void track_request(input t_in_req r);
        int      v;
        t_result res;
        if (r.func == FUNC_LOAD) begin
            table_low[r.entry_index]  = r.range_low;
            table_high[r.entry_index] = r.range_high;
            return;
        end
        if (r.char_code >= CHAR_ZERO && r.char_code <= CHAR_NINE) begin
            v = int'(octet_acc) * 10 + int'(r.char_code - CHAR_ZERO);
            if (v > int'(OCTET_MAX)) begin
                text_bad  = 1'b1;
                octet_acc = OCTET_SAT;
            end else begin
                octet_acc = 9'(v);
            end
        end else if (r.char_code == CHAR_DOT) begin
            if (dots_seen >= DOT_LAST) begin
                text_bad = 1'b1;
            end else begin
                addr_acc  = {addr_acc[15:0], octet_byte()};
                octet_acc = '0;
                dots_seen = dots_seen + 2'd1;
            end
        end else begin
            text_bad = 1'b1;
        end
        if (!r.last_char)
            return;
        res.address   = {addr_acc, octet_byte()};
        res.bucket    = search_bucket(res.address);
        res.malformed = text_bad;
        expected_results.push_back(res);
        octet_acc = '0;
        addr_acc  = '0;
        dots_seen = '0;
        text_bad  = 1'b0;
    endfunction

    // ---------------------------------------------------------------- request building

    function automatic t_in_req load_req(input logic [7:0] slot, input logic [31:0] lo,
                                         input logic [31:0] hi);
        t_in_req r;
        r.func        = FUNC_LOAD;
        r.entry_index = slot;
        r.range_low   = lo;
        r.range_high  = hi;
        r.char_code   = 8'($urandom);
        r.last_char   = 1'($urandom);
        return r;
    endfunction

    function automatic t_in_req char_req(input logic [7:0] c, input bit last);
        t_in_req r;
        r.func        = FUNC_CHAR;
        r.entry_index = 8'($urandom);
        r.range_low   = $urandom;
        r.range_high  = $urandom;
        r.char_code   = c;
        r.last_char   = last;
        return r;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_DOT);
        return c;
    endfunction

    // Pick an address at or next to a loaded range bound, or inside a range, most of the time
    function automatic logic [31:0] pick_target();
        int k;
        if (active_entries() == 0 || $urandom_range(0, 2) == 0)
            return $urandom;
        k = $urandom_range(0, active_entries() - 1);
        case ($urandom_range(0, 4))
            0:       return table_low[k];
            1:       return table_high[k];
            2:       return table_low[k] - 32'd1;
            3:       return table_high[k] + 32'd1;
            default: return table_low[k] + (table_high[k] - table_low[k]) / 2;
        endcase
    endfunction

    task automatic put_number(input int value, input bit pad);
        if (pad || value >= 100)
            text_buf.push_back(8'(CHAR_ZERO + value / 100));
        if (pad || value >= 10)
            text_buf.push_back(8'(CHAR_ZERO + (value / 10) % 10));
        text_buf.push_back(8'(CHAR_ZERO + value % 10));
    endtask

    // Build dotted text; about a third of the addresses carry one defect
    task automatic build_address_text();
        logic [31:0] target;
        int          bad_octet;
        int          fault;
        int          octet;
        text_buf.delete();
        target    = pick_target();
        bad_octet = ($urandom_range(0, 99) < 68) ? -1 : $urandom_range(0, 3);
        fault     = $urandom_range(0, 5);
        for (int k = 0; k < 4; k++) begin
            octet = int'(target[8 * (3 - k) +: 8]);
            if (k != bad_octet) begin
                put_number(octet, $urandom_range(0, 9) == 0);
            end else begin
                case (fault)
                    0: begin
                        put_number(octet, 1'b0);
                        text_buf.push_back(junk_char());
                    end
                    1: put_number($urandom_range(256, 999), 1'b0);
                    2: ;  // leave the octet empty
                    3: begin
                        put_number(octet, 1'b0);
                        text_buf.push_back(CHAR_DOT);
                    end
                    4: begin
                        put_number(octet, 1'b0);
                        break;
                    end
                    default: put_number(octet, 1'b0);
                endcase
            end
            if (k != 3)
                text_buf.push_back(CHAR_DOT);
        end
        // Trailing extra octet
        if (bad_octet >= 0 && fault == 5) begin
            text_buf.push_back(CHAR_DOT);
            put_number($urandom_range(0, 255), 1'b0);
        end
    endtask

    // ---------------------------------------------------------------- driving

    // Offer one request and hold it until accepted; valid stays high afterwards
    task automatic send_req(input t_in_req req);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        track_request(req);
    endtask

    task automatic release_bus();
        i_valid <= 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_req(char_req(8'(s[i]), i == s.len() - 1));
    endtask

    // Wait for all results, then let any search on a load-only tail finish
    task automatic wait_quiet();
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SEARCH_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_entry_count(input int count);
        i_cfg_we    <= 1'b1;
        i_cfg_data  <= 9'(count);
        @(posedge i_clk);
        entries_cfg = count;
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_table(input int count, input bit sorted);
        longint unsigned step;
        longint unsigned base;
        logic [31:0]     lo;
        logic [31:0]     hi;
        if (count == 0)
            return;
        step = (64'd1 << 32) / count;
        for (int k = 0; k < count; k++) begin
            if (sorted) begin
                base = step * k;
                lo   = 32'(base + $urandom_range(0, 32'(step / 4)));
                hi   = ($urandom_range(0, 7) == 0) ? lo : lo + $urandom_range(0, 32'(step / 2));
                if (k == 0 && $urandom_range(0, 1) == 0)
                    lo = '0;
                if (k == count - 1 && $urandom_range(0, 1) == 0)
                    hi = '1;
            end else begin
                lo = $urandom;
                hi = ($urandom_range(0, 1) == 0) ? lo + $urandom_range(0, 65535) : $urandom;
            end
            send_req(load_req(8'(k), lo, hi));
        end
    endtask

    // Load the first entries of the table, then make them active
    task automatic prepare_table(input int count, input bit sorted);
        wait_quiet();
        load_table(count, sorted);
        release_bus();
        wait_quiet();
        write_entry_count(count);
    endtask

    // Stream addresses with an occasional table rewrite mixed in
    task automatic send_addresses(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            build_address_text();
            foreach (text_buf[i]) begin
                if ($urandom_range(0, 49) == 0) begin
                    send_req(load_req(8'($urandom), $urandom, $urandom));
                    sent++;
                end
                send_req(char_req(text_buf[i], i == text_buf.size() - 1));
                sent++;
            end
        end
        release_bus();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_parse_cases();
        tx_idle_pct = 20;
        rx_idle_pct = 47;
        // Empty table: default bucket is zero
        send_text("7");
        send_req(load_req(8'd0, 32'h0000_0000, 32'h0000_00FF));
        send_req(load_req(8'd1, 32'h0100_0000, 32'hFFFF_FFFF));
        send_req(load_req(8'd255, $urandom, $urandom));
        release_bus();
        wait_quiet();
        write_entry_count(2);
        // Saturated octet, dot overflow with empty octets, trailing dot
        send_text("300");
        send_text("....");
        send_text("1.");
        // Lowest and highest character codes
        send_req(char_req(8'h00, 1'b0));
        send_req(char_req(8'hFF, 1'b1));
        send_text("255.255.255.255");
        release_bus();
    endtask

    task automatic test_full_table();
        prepare_table(TABLE_DEPTH, 1'b1);
        send_addresses(180);
    endtask

    task automatic test_small_table();
        tx_idle_pct = 47;
        rx_idle_pct = 20;
        prepare_table($urandom_range(2, 40), 1'b1);
        send_addresses(200);
    endtask

    task automatic test_unsorted_table();
        prepare_table($urandom_range(3, 12), 1'b0);
        send_addresses(120);
    endtask

    task automatic test_edge_counts();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        prepare_table(1, 1'b1);
        send_addresses(50);
        prepare_table(0, 1'b1);
        send_addresses(30);
    endtask

    // Hold the output for a long stretch while requests keep coming
    task automatic test_backpressure();
        prepare_table(8, 1'b1);
        rx_hold_request = HOLD_CYCLES;
        send_addresses(40);
    endtask

    // ---------------------------------------------------------------- receiver and checks

    always @(posedge i_clk) begin
        if (rx_hold_request != 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result: address %h bucket %0d malformed %0b",
                             o_res.address, o_res.bucket, o_res.malformed);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_res.address !== want.address || o_res.bucket !== want.bucket ||
                    o_res.malformed !== want.malformed) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                                 want.address, want.bucket, want.malformed,
                                 o_res.address, o_res.bucket, o_res.malformed);
                    mismatch_count++;
                end
            end
        end
    end

    // Stop when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            stuck_cycles = 0;
        else
            stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_parse_cases();
        test_full_table();
        test_small_table();
        test_unsorted_table();
        test_edge_counts();
        test_backpressure();
        wait_quiet();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
